// ===== rtl/jpdd_pkg.sv =====
`timescale 1ns / 1ps

package jpdd_pkg;

    // Command bytes recognized while no packet is in progress.
    localparam logic [7:0] CMD_RESET_BYTE = 8'h52;  // 'R'
    localparam logic [7:0] CMD_WIN_BYTE   = 8'h6F;  // 'o'

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_CENTER  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_INTERVAL = 3'd4;

    // Register values after reset.
    localparam logic [7:0]  HEADER_FIRST_RESET  = 8'd170;
    localparam logic [7:0]  HEADER_SECOND_RESET = 8'd85;
    localparam logic [15:0] STICK_CENTER_RESET  = 16'd512;
    localparam logic [15:0] DEAD_ZONE_RESET     = 16'd100;
    localparam logic [15:0] HOLD_INTERVAL_RESET = 16'd110;

    // Byte positions inside a packet.
    localparam logic [2:0] POS_IDLE   = 3'd0;
    localparam logic [2:0] POS_HEADER = 3'd1;
    localparam logic [2:0] POS_X_LO   = 3'd2;
    localparam logic [2:0] POS_X_HI   = 3'd3;
    localparam logic [2:0] POS_Y_LO   = 3'd4;
    localparam logic [2:0] POS_Y_HI   = 3'd5;
    localparam logic [2:0] POS_SPARE  = 3'd6;
    localparam logic [2:0] POS_CHECK  = 3'd7;

    typedef enum logic [2:0] {
        DIR_CENTERED = 3'd0,
        DIR_NORTH    = 3'd1,
        DIR_SOUTH    = 3'd2,
        DIR_EAST     = 3'd3,
        DIR_WEST     = 3'd4
    } dir_t;

    // One result item; packs into m_tdata with direction in the lowest bits.
    typedef struct packed {
        logic win_event;
        logic reset_event;
        logic packet_good;
        logic packet_done;
        dir_t direction;
    } result_t;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

endpackage

// ===== rtl/joystick_packet_direction_decoder_unit.sv =====
`timescale 1ns / 1ps

// Each result is registered onto m_tdata in the cycle after its byte transfer.
// Throughput: one byte per cycle unless m_tready stalls; the single result register
// is refilled as it is drained, so s_tready follows m_tready when a result is held.
// Reset: synchronous, active low on aresetn; clears the packet position, checksum,
// axis values and direction history, and restores the configuration defaults.
module joystick_packet_direction_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream. s_tdata fields from bit 0: rx_byte[7:0], time_ms[39:8].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jpdd_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream. m_tdata fields from bit 0: direction[2:0], packet_done[3],
    // packet_good[4], reset_event[5], win_event[6], zero[7].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jpdd_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jpdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jpdd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jpdd_pkg::*;

    // Configuration registers.
    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;
    logic [15:0] stick_center_reg;
    logic [15:0] dead_zone_reg;
    logic [15:0] hold_interval_reg;

    // Packet parsing state.
    logic [2:0]  byte_position_reg,  byte_position_next;
    logic [7:0]  running_check_reg,  running_check_next;
    logic [15:0] x_raw_reg,          x_raw_next;
    logic [15:0] y_raw_reg,          y_raw_next;
    dir_t        prev_dir_reg,       prev_dir_next;
    logic [31:0] prev_time_reg,      prev_time_next;

    // Result register.
    logic        m_tvalid_reg;
    result_t     result_reg,         result_next;

    logic        s_xfer;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;

    // Stick classification signals.
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [16:0] dz_ext;
    dir_t        stick_dir;
    logic [31:0] elapsed;
    logic        hold_passed;

    assign rx_byte  = s_tdata[7:0];
    assign time_ms  = s_tdata[39:8];

    // The result register can take a new item whenever it is empty or being drained.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};

    // Configuration writes. Indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            stick_center_reg  <= STICK_CENTER_RESET;
            dead_zone_reg     <= DEAD_ZONE_RESET;
            hold_interval_reg <= HOLD_INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                CFG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                CFG_STICK_CENTER:  stick_center_reg  <= cfg_data;
                CFG_DEAD_ZONE:     dead_zone_reg     <= cfg_data;
                CFG_HOLD_INTERVAL: hold_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Centered offsets are taken at 17 bits so no value saturates. The magnitude
    // of a 17-bit difference of two 16-bit values always fits in 16 bits.
    always_comb begin
        dx     = {1'b0, x_raw_reg} - {1'b0, stick_center_reg};
        dy     = {1'b0, y_raw_reg} - {1'b0, stick_center_reg};
        ax     = dx[16] ? (17'd0 - dx) : dx;
        ay     = dy[16] ? (17'd0 - dy) : dy;
        dz_ext = {1'b0, dead_zone_reg};
        if (ax <= dz_ext && ay <= dz_ext) begin
            stick_dir = DIR_CENTERED;
        end else if (ay > ax) begin
            stick_dir = dy[16] ? DIR_NORTH : DIR_SOUTH;
        end else begin
            // Ties between the axes go to X.
            stick_dir = dx[16] ? DIR_WEST : DIR_EAST;
        end
    end

    // Elapsed time wraps modulo 2^32 along with the millisecond counter.
    assign elapsed     = time_ms - prev_time_reg;
    assign hold_passed = elapsed >= {16'd0, hold_interval_reg};

    // Per-byte parser: one decision per accepted byte.
    always_comb begin
        byte_position_next = byte_position_reg;
        running_check_next = running_check_reg;
        x_raw_next         = x_raw_reg;
        y_raw_next         = y_raw_reg;
        prev_dir_next      = prev_dir_reg;
        prev_time_next     = prev_time_reg;
        result_next        = '0;
        result_next.direction = DIR_CENTERED;

        unique case (byte_position_reg)
            POS_IDLE: begin
                // Command bytes take priority over the first header byte.
                if (rx_byte == CMD_RESET_BYTE) begin
                    result_next.reset_event = 1'b1;
                end else if (rx_byte == CMD_WIN_BYTE) begin
                    result_next.win_event = 1'b1;
                end else if (rx_byte == header_first_reg) begin
                    running_check_next = rx_byte;
                    byte_position_next = POS_HEADER;
                end
            end
            POS_HEADER: begin
                // A repeated first header byte restarts the hunt in place.
                if (rx_byte == header_second_reg) begin
                    running_check_next = running_check_reg ^ rx_byte;
                    byte_position_next = POS_X_LO;
                end else if (rx_byte == header_first_reg) begin
                    running_check_next = rx_byte;
                end else begin
                    byte_position_next = POS_IDLE;
                end
            end
            POS_X_LO, POS_X_HI, POS_Y_LO, POS_Y_HI, POS_SPARE: begin
                if (byte_position_reg == POS_X_LO) x_raw_next[7:0]  = rx_byte;
                if (byte_position_reg == POS_X_HI) x_raw_next[15:8] = rx_byte;
                if (byte_position_reg == POS_Y_LO) y_raw_next[7:0]  = rx_byte;
                if (byte_position_reg == POS_Y_HI) y_raw_next[15:8] = rx_byte;
                running_check_next = running_check_reg ^ rx_byte;
                byte_position_next = byte_position_reg + 3'd1;
            end
            POS_CHECK: begin
                result_next.packet_done = 1'b1;
                byte_position_next      = POS_IDLE;
                if (running_check_reg == rx_byte) begin
                    result_next.packet_good = 1'b1;
                    if (stick_dir != DIR_CENTERED) begin
                        // Report a new direction at once; repeat one only after
                        // the hold interval has passed.
                        if (stick_dir != prev_dir_reg || hold_passed) begin
                            result_next.direction = stick_dir;
                            prev_dir_next         = stick_dir;
                            prev_time_next        = time_ms;
                        end
                    end else begin
                        // A centered stick forgets the last direction.
                        prev_dir_next = DIR_CENTERED;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= POS_IDLE;
            running_check_reg <= '0;
            x_raw_reg         <= '0;
            y_raw_reg         <= '0;
            prev_dir_reg      <= DIR_CENTERED;
            prev_time_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (s_xfer) begin
                byte_position_reg <= byte_position_next;
                running_check_reg <= running_check_next;
                x_raw_reg         <= x_raw_next;
                y_raw_reg         <= y_raw_next;
                prev_dir_reg      <= prev_dir_next;
                prev_time_reg     <= prev_time_next;
                m_tvalid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg      <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only seen while m_tvalid is high.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== rtl/jpdd_checker.sv =====
`timescale 1ns / 1ps

module jpdd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [jpdd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import jpdd_pkg::*;

    result_t res;
    assign res = result_t'(m_tdata[6:0]);

    // A held result keeps its value until it is taken.
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A good checksum is only reported for a finished packet.
    a_good_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.packet_good |-> res.packet_done)
        else $error("packet_good without packet_done");

    // Directions come only from packets whose checksum matched.
    a_dir_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.direction != DIR_CENTERED) |-> res.packet_good)
        else $error("direction reported without a good packet");

    // Command events and packet completion come from different byte positions.
    a_events_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones({res.reset_event, res.win_event, res.packet_done}) <= 1)
        else $error("command event overlaps another event");

endmodule

bind joystick_packet_direction_decoder_unit jpdd_checker u_jpdd_checker (.*);
